[sv/ddss_pkg.sv]
// Package with shared types, constants and a helper function for the drum sequencer.
package ddss_pkg;

    localparam int SAMPLE_DEPTH   = 8192;
    localparam int SEQUENCE_SLOTS = 8;
    localparam int ADDR_W         = $clog2(SAMPLE_DEPTH);
    localparam int LEN_W          = ADDR_W + 1;
    localparam int SLOT_W         = (SEQUENCE_SLOTS > 1) ? $clog2(SEQUENCE_SLOTS) : 1;
    localparam int RATE_W         = 18;
    localparam int GAIN_W         = 16;
    localparam int DIV_W          = 32;
    localparam int MIX_W          = 36;

    // Command codes.
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_KICK  = 3'd1;
    localparam logic [2:0] CMD_SNARE = 3'd2;
    localparam logic [2:0] CMD_HIHAT = 3'd3;
    localparam logic [2:0] CMD_DENS  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_KICK_LEN  = 3'd0;
    localparam logic [2:0] REG_SNARE_LEN = 3'd1;
    localparam logic [2:0] REG_HIHAT_LEN = 3'd2;
    localparam logic [2:0] REG_RATE      = 3'd3;
    localparam logic [2:0] REG_SEQ_LEN   = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch input item
        logic write_mem; // perform store of a load command
        logic beat;      // start a beat, begin tempo division
        logic fetch;     // read sample memories
        logic mix;       // register voice products and sum
        logic clip;      // start soft-clip division
        logic finish;    // register result
    } ddss_cmd_t;

    typedef struct packed {
        logic       is_tick;
        logic       beat_due;
        logic       div_busy;
    } ddss_stat_t;

    // Gain per density: round(16384*((d+1)/11)^3*(d>=7?2:1)).
    function automatic logic [GAIN_W-1:0] gain_of(input logic [3:0] d);
        logic [GAIN_W-1:0] g;
        begin
            unique case (d)
                4'd0:    g = 16'd12;
                4'd1:    g = 16'd98;
                4'd2:    g = 16'd332;
                4'd3:    g = 16'd788;
                4'd4:    g = 16'd1539;
                4'd5:    g = 16'd2659;
                4'd6:    g = 16'd4222;
                4'd7:    g = 16'd12605;
                4'd8:    g = 16'd17947;
                4'd9:    g = 16'd24619;
                default: g = 16'd32768;
            endcase
            return g;
        end
    endfunction

endpackage

[sv/density_drum_sample_sequencer.sv]
// Top level of the three-voice density-paced drum sample sequencer.
//
// Input channel (in_valid/in_stall) carries command, address and value.
// Load commands write a sample word or a density slot and give no result.
// A tick command gives one soft-clipped audio_out transfer on the output
// channel (out_valid/out_stall).
// One item is worked at a time. A load is latched and then stored. A tick
// waits on the 17-step soft-clip divider; a tick that starts a beat also
// waits first on the 32-step tempo reload divider.
// The result sits in an output register, so a stalled receiver holds it
// while the next item is already taken; a second result waits for it.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
// Reset restores the default density sequence, a gain of one, idle
// voices, a zero beat counter and the default register values. The
// sample memories have no reset and must be loaded before playback.
module density_drum_sample_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [12:0]        address,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] audio_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data
);
    import ddss_pkg::*;

    ddss_cmd_t  cmd;
    ddss_stat_t stat;

    ddss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ddss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command),
        .address   (address),
        .value     (value),
        .audio_out (audio_out)
    );

    // A result transfer never coincides with an item latch of a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !cmd.load)
        else $error("finish and load overlap");

    // Held result stays stable while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(audio_out)))
        else $error("stalled result changed");

    // No new result is produced while one is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.finish)
        else $error("result overwritten");
endmodule

[sv/ddss_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module ddss_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ddss_pkg::DIV_W-1:0] dividend,
    input  logic [ddss_pkg::DIV_W-1:0] divisor,
    output logic                    busy,
    output logic [ddss_pkg::DIV_W-1:0] quotient
);
    import ddss_pkg::*;

    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W:0]     rem_reg;
    logic [DIV_W-1:0]   dvs_reg;
    logic [5:0]         cnt_reg;
    logic [DIV_W:0]     shifted;
    logic [DIV_W:0]     trial;

    // One shift-subtract step.
    always_comb
    begin
        shifted = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'(DIV_W);
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = quo_reg;
endmodule

[sv/ddss_datapath.sv]
// Datapath: stores, voice positions, tempo counter, mixer and soft clip.
module ddss_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ddss_pkg::ddss_cmd_t     cmd,
    output ddss_pkg::ddss_stat_t    stat,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [17:0]             cfg_data,
    input  logic [2:0]              command,
    input  logic [12:0]             address,
    input  logic signed [15:0]      value,
    output logic signed [16:0]      audio_out
);
    import ddss_pkg::*;

    logic [LEN_W-1:0]  kick_len_reg, snare_len_reg, hihat_len_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [3:0]        seq_len_reg;

    logic [2:0]         cmd_reg;
    logic [12:0]        addr_reg;
    logic signed [15:0] val_reg;

    logic signed [15:0] kick_mem  [SAMPLE_DEPTH];
    logic signed [15:0] snare_mem [SAMPLE_DEPTH];
    logic signed [15:0] hihat_mem [SAMPLE_DEPTH];
    logic signed [15:0] kick_rd, snare_rd, hihat_rd;

    logic [3:0]        dens_reg [SEQUENCE_SLOTS];
    logic [SLOT_W-1:0] idx_reg;
    logic [RATE_W-1:0] count_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]  kpos_reg, spos_reg, hpos_reg;
    logic              kact_reg, sact_reg, hact_reg;
    logic              kon_reg, son_reg, hon_reg;
    logic              tempo_pend_reg;

    logic signed [MIX_W-1:0] mix_reg;
    logic                    neg_reg;
    logic signed [16:0]      out_reg;

    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_a, div_b, div_q;
    logic [3:0]         d_cur;
    logic [LEN_W-1:0]   klim, slim, hlim;
    logic [SLOT_W:0]    slots;
    logic [SLOT_W:0]    idx_inc;
    logic [MIX_W-1:0]   mag;
    logic [MIX_W-1:0]   den;
    logic [DIV_W-1:0]   q_half;
    logic [3:0]         dens_sat;

    function automatic logic [LEN_W-1:0] clamp(input logic [LEN_W-1:0] n);
        return (n > LEN_W'(SAMPLE_DEPTH)) ? LEN_W'(SAMPLE_DEPTH) : n;
    endfunction

    // Density and sequence bounds.
    always_comb
    begin
        d_cur = dens_reg[idx_reg];
        if (seq_len_reg == 4'd0)
            slots = (SLOT_W+1)'(1);
        else if ({1'b0, seq_len_reg} > 5'(SEQUENCE_SLOTS))
            slots = (SLOT_W+1)'(SEQUENCE_SLOTS);
        else
            slots = (SLOT_W+1)'(seq_len_reg);
        idx_inc  = {1'b0, idx_reg} + (SLOT_W+1)'(1);
        klim     = clamp(kick_len_reg);
        slim     = clamp(snare_len_reg);
        hlim     = clamp(hihat_len_reg);
        if (val_reg < 0)
            dens_sat = 4'd0;
        else if (val_reg > 16'sd10)
            dens_sat = 4'd10;
        else
            dens_sat = val_reg[3:0];
        mag    = mix_reg[MIX_W-1] ? MIX_W'(-mix_reg) : MIX_W'(mix_reg);
        den    = MIX_W'(64'h8000_0000) + mag;
    end

    // Division operands for the tempo reload.
    always_comb
    begin
        div_start = cmd.beat;
        div_a     = DIV_W'(rate_reg) * DIV_W'(10);
        div_b     = DIV_W'(10) + DIV_W'(d_cur) * DIV_W'(9);
    end

    ddss_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Soft clip ratio: mag < 2^35, result below 2^17. Computed as mag*2^16/den rounded.
    logic [DIV_W-1:0] clip_q;
    logic [5:0]       clip_cnt_reg;
    logic [MIX_W+17:0] crem_reg;
    logic [16:0]      cq_reg;
    logic [MIX_W+17:0] cden2;
    assign cden2  = (MIX_W+18)'(den) << 1;
    assign clip_q = DIV_W'(cq_reg);
    assign q_half = clip_q;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_len_reg  <= '0;
            snare_len_reg <= '0;
            hihat_len_reg <= '0;
            rate_reg      <= RATE_W'(44100);
            seq_len_reg   <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KICK_LEN:  kick_len_reg  <= cfg_data[LEN_W-1:0];
                REG_SNARE_LEN: snare_len_reg <= cfg_data[LEN_W-1:0];
                REG_HIHAT_LEN: hihat_len_reg <= cfg_data[LEN_W-1:0];
                REG_RATE:      rate_reg      <= cfg_data;
                REG_SEQ_LEN:   seq_len_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input item latch.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            addr_reg <= address;
            val_reg  <= value;
        end
    end

    // Sample memories.
    always_ff @(posedge clk)
    begin
        if (cmd.write_mem && (cmd_reg == CMD_KICK) && ({1'b0, addr_reg} < 14'(SAMPLE_DEPTH)))
            kick_mem[addr_reg[ADDR_W-1:0]] <= val_reg;
        if (cmd.write_mem && (cmd_reg == CMD_SNARE) && ({1'b0, addr_reg} < 14'(SAMPLE_DEPTH)))
            snare_mem[addr_reg[ADDR_W-1:0]] <= val_reg;
        if (cmd.write_mem && (cmd_reg == CMD_HIHAT) && ({1'b0, addr_reg} < 14'(SAMPLE_DEPTH)))
            hihat_mem[addr_reg[ADDR_W-1:0]] <= val_reg;
        if (cmd.fetch)
        begin
            kick_rd  <= kick_mem[kpos_reg[ADDR_W-1:0]];
            snare_rd <= snare_mem[spos_reg[ADDR_W-1:0]];
            hihat_rd <= hihat_mem[hpos_reg[ADDR_W-1:0]];
        end
    end

    // Sequence, voices and tempo state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dens_reg[0] <= 4'd1; dens_reg[1] <= 4'd3; dens_reg[2] <= 4'd6;
            dens_reg[3] <= 4'd2; dens_reg[4] <= 4'd8; dens_reg[5] <= 4'd4;
            dens_reg[6] <= 4'd9; dens_reg[7] <= 4'd5;
            idx_reg        <= '0;
            count_reg      <= '0;
            gain_reg       <= GAIN_W'(16384);
            kpos_reg <= '0; spos_reg <= '0; hpos_reg <= '0;
            kact_reg <= 1'b0; sact_reg <= 1'b0; hact_reg <= 1'b0;
            kon_reg  <= 1'b0; son_reg  <= 1'b0; hon_reg  <= 1'b0;
            tempo_pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_mem && (cmd_reg == CMD_DENS) && ({1'b0, addr_reg} < 14'(SEQUENCE_SLOTS)))
                dens_reg[addr_reg[SLOT_W-1:0]] <= dens_sat;
            if (cmd.beat)
            begin
                gain_reg <= gain_of(d_cur);
                kact_reg <= 1'b1; kpos_reg <= '0;
                hact_reg <= 1'b1; hpos_reg <= '0;
                if (d_cur >= 4'd4)
                begin
                    sact_reg <= 1'b1; spos_reg <= '0;
                end
                idx_reg <= (idx_inc >= slots) ? '0 : idx_inc[SLOT_W-1:0];
                tempo_pend_reg <= 1'b1;
            end
            if (tempo_pend_reg && !div_busy && !cmd.beat)
            begin
                count_reg      <= div_q[RATE_W-1:0];
                tempo_pend_reg <= 1'b0;
            end
            if (cmd.fetch)
            begin
                kon_reg <= kact_reg && (kpos_reg < klim);
                son_reg <= sact_reg && (spos_reg < slim);
                hon_reg <= hact_reg && (hpos_reg < hlim);
                if (kact_reg && (kpos_reg < klim)) kpos_reg <= kpos_reg + 1'b1;
                else kact_reg <= 1'b0;
                if (sact_reg && (spos_reg < slim)) spos_reg <= spos_reg + 1'b1;
                else sact_reg <= 1'b0;
                if (hact_reg && (hpos_reg < hlim)) hpos_reg <= hpos_reg + 1'b1;
                else hact_reg <= 1'b0;
            end
            if (cmd.finish && (count_reg != '0))
                count_reg <= count_reg - 1'b1;
        end
    end

    // Mix: 2*(k+s)*g + h*g.
    logic signed [17:0] ks_sum;
    logic signed [18:0] ks2h;
    assign ks_sum = 18'(kon_reg ? kick_rd : 16'sd0) + 18'(son_reg ? snare_rd : 16'sd0);
    assign ks2h   = (19'(ks_sum) <<< 1) + 19'(hon_reg ? hihat_rd : 16'sd0);

    always_ff @(posedge clk)
    begin
        if (cmd.mix)
            mix_reg <= MIX_W'(ks2h) * $signed({1'b0, gain_reg});
    end

    // Soft clip: q = (mag*2^17 + den) / (2*den), one bit per cycle, 17 bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clip_cnt_reg <= '0;
        else if (cmd.clip)
            clip_cnt_reg <= 6'd17;
        else if (clip_cnt_reg != 6'd0)
            clip_cnt_reg <= clip_cnt_reg - 6'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            crem_reg <= ((MIX_W+18)'(mag) << 17) + (MIX_W+18)'(den);
            cq_reg   <= '0;
            neg_reg  <= mix_reg[MIX_W-1];
        end
        else if (clip_cnt_reg != 6'd0)
        begin
            if (crem_reg >= (cden2 << (clip_cnt_reg[4:0] - 5'd1)))
            begin
                crem_reg <= crem_reg - (cden2 << (clip_cnt_reg[4:0] - 5'd1));
                cq_reg   <= {cq_reg[15:0], 1'b1};
            end
            else
            begin
                cq_reg <= {cq_reg[15:0], 1'b0};
            end
        end
        if (cmd.finish)
            out_reg <= neg_reg ? -$signed(q_half[16:0]) : $signed(q_half[16:0]);
    end

    assign audio_out     = out_reg;
    assign stat.is_tick  = (cmd_reg == CMD_TICK);
    assign stat.beat_due = (count_reg == '0);
    assign stat.div_busy = div_busy || tempo_pend_reg || (clip_cnt_reg != 6'd0);
endmodule

[sv/ddss_ctrl.sv]
// Controller: sequences one item through load, then a store or beat, fetch, mix, clip and output.
module ddss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ddss_pkg::ddss_cmd_t  cmd,
    input  ddss_pkg::ddss_stat_t stat
);
    import ddss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WAITB, S_FETCH, S_MIX, S_CLIP, S_WAITC, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (!stat.is_tick)
                begin
                    cmd.write_mem = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.beat_due)
                begin
                    cmd.beat   = 1'b1;
                    state_next = S_WAITB;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_WAITB:
                if (!stat.div_busy)
                    state_next = S_FETCH;
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = S_WAITC;
            end
            S_WAITC:
                if (!stat.div_busy)
                    state_next = S_DONE;
            S_DONE:
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

[test/density_drum_sample_sequencer_checker.sv]
// Checker that predicts the drum sequencer output and compares every audio transfer.
module density_drum_sample_sequencer_checker
    import ddss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         command,
    input  logic [12:0]        address,
    input  logic signed [15:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [16:0] audio_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data,
    output int                 failures,
    output int                 pending
);

    localparam int VOICE_KICK  = 0;
    localparam int VOICE_SNARE = 1;
    localparam int VOICE_HIHAT = 2;

    // Predicted state of the sequencer.
    logic signed [15:0] voice_mem [3][SAMPLE_DEPTH];
    logic [13:0]        voice_len [3];
    int unsigned        voice_pos [3];
    bit                 voice_on  [3];
    logic [17:0]        rate_reg;
    logic [3:0]         seq_len_reg;
    int unsigned        density_slot [SEQUENCE_SLOTS];
    int unsigned        slot_ptr;
    longint unsigned    beat_count;
    longint unsigned    gain_now;
    logic [16:0]        audio_q [$];

    // Soft clip y = x/(1+|x|/2), x in units of 2^-30, y in Q2.15, ties away from zero.
    function automatic logic [16:0] clip_sample(input longint s);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        begin
            mag = (s < 0) ? longint'(-s) : longint'(s);
            den = (64'd1 << 31) + mag;
            q = ((mag << 17) + den) / (2 * den);
            r = (s < 0) ? (64'd0 - q) : q;
            return r[16:0];
        end
    endfunction

    // Next word of one voice, or zero once it has run past its length.
    function automatic longint voice_word(input int v);
        int unsigned lim;
        begin
            lim = (voice_len[v] > SAMPLE_DEPTH) ? SAMPLE_DEPTH : voice_len[v];
            if (voice_on[v] && voice_pos[v] < lim) begin
                voice_pos[v] = voice_pos[v] + 1;
                return longint'(voice_mem[v][voice_pos[v] - 1]);
            end
            voice_on[v] = 1'b0;
            return 0;
        end
    endfunction

    // Beat start: fetch the density, set gain, retrigger voices, reload the counter.
    task automatic begin_beat();
        int unsigned slots;
        int unsigned idx;
        longint unsigned d;
        longint unsigned num;
        begin
            slots = seq_len_reg;
            if (slots < 1) slots = 1;
            if (slots > SEQUENCE_SLOTS) slots = SEQUENCE_SLOTS;
            idx = (slot_ptr >= SEQUENCE_SLOTS) ? 0 : slot_ptr;
            d = density_slot[idx];
            if (d > 10) d = 10;
            num = (d + 1) * (d + 1) * (d + 1) * 16384 * ((d >= 7) ? 2 : 1);
            gain_now = (2 * num + 1331) / 2662;
            voice_on[VOICE_KICK] = 1'b1;
            voice_pos[VOICE_KICK] = 0;
            // The snare only restarts on the denser beats.
            if (d >= 4) begin
                voice_on[VOICE_SNARE] = 1'b1;
                voice_pos[VOICE_SNARE] = 0;
            end
            voice_on[VOICE_HIHAT] = 1'b1;
            voice_pos[VOICE_HIHAT] = 0;
            beat_count = (longint'(rate_reg) * 10) / (10 + 9 * d);
            idx = idx + 1;
            slot_ptr = (idx >= slots) ? 0 : idx;
        end
    endtask

    // Apply one accepted input transfer to the predicted state.
    task automatic apply_item(input logic [2:0] cmd, input logic [12:0] addr,
                              input logic signed [15:0] val);
        longint k;
        longint s;
        longint h;
        begin
            case (cmd)
                CMD_KICK:  voice_mem[VOICE_KICK][addr] = val;
                CMD_SNARE: voice_mem[VOICE_SNARE][addr] = val;
                CMD_HIHAT: voice_mem[VOICE_HIHAT][addr] = val;
                CMD_DENS:
                begin
                    if (addr < SEQUENCE_SLOTS)
                        density_slot[addr] = (val < 0) ? 0 : ((val > 10) ? 10 : val);
                end
                CMD_TICK:
                begin
                    if (beat_count == 0) begin_beat();
                    k = voice_word(VOICE_KICK);
                    s = voice_word(VOICE_SNARE);
                    h = voice_word(VOICE_HIHAT);
                    if (beat_count > 0) beat_count = beat_count - 1;
                    audio_q.push_back(clip_sample(2 * (k + s) * longint'(gain_now)
                                                  + h * longint'(gain_now)));
                end
                default: ;
            endcase
        end
    endtask

    // Watch configuration writes, input transfers and output transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < 3; v++)
            begin
                voice_len[v] = '0;
                voice_pos[v] = 0;
                voice_on[v] = 1'b0;
            end
            rate_reg = 18'd44100;
            seq_len_reg = 4'd8;
            density_slot = '{1, 3, 6, 2, 8, 4, 9, 5};
            slot_ptr = 0;
            beat_count = 0;
            gain_now = 16384;
            audio_q.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KICK_LEN:  voice_len[VOICE_KICK] = cfg_data[13:0];
                    REG_SNARE_LEN: voice_len[VOICE_SNARE] = cfg_data[13:0];
                    REG_HIHAT_LEN: voice_len[VOICE_HIHAT] = cfg_data[13:0];
                    REG_RATE:      rate_reg = cfg_data;
                    REG_SEQ_LEN:   seq_len_reg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                apply_item(command, address, value);
            if (out_valid && !out_stall)
            begin
                if (audio_q.size() == 0)
                begin
                    $display("%0t: unexpected audio transfer, expected none, actual %0d",
                             $time, audio_out);
                    failures++;
                end
                else
                begin
                    if (audio_out !== audio_q[0])
                    begin
                        $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                                 $time, $signed(audio_q[0]), audio_out);
                        failures++;
                    end
                    void'(audio_q.pop_front());
                end
            end
            pending = audio_q.size();
        end
    end

endmodule

[test/density_drum_sample_sequencer_test.sv]
// Testbench top: drives stimulus and configuration and reports the verdict.
module density_drum_sample_sequencer_test;
    import ddss_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;
    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         LONG_HOLD   = 3000;
    localparam int         FILL_WORDS  = 64;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic [12:0]        address;
    logic signed [15:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] audio_out;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [17:0]        cfg_data;
    int                 failures;
    int                 pending;
    int                 burst_left;
    bit                 hold_req;
    longint             cycles;

    density_drum_sample_sequencer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .audio_out(audio_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    density_drum_sample_sequencer_checker audio_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .address(address), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .audio_out(audio_out),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int stall_pct;
        int span_left;
        int hold_left;
        bit hold_done;
        stall_pct = 0;
        span_left = 0;
        hold_left = 0;
        hold_done = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (span_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                span_left = $urandom_range(20, 300);
            end
            span_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // One input transfer, sent in bursts with gaps between them.
    task automatic send_item(input logic [2:0] cmd, input logic [12:0] addr,
                             input logic [15:0] val);
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            in_valid <= 1'b1;
            command <= cmd;
            address <= addr;
            value <= val;
            do @(posedge clk); while (in_stall);
            burst_left--;
        end
    endtask

    // Wait until every predicted sample has arrived and the block has settled.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (100) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Voice length: mostly short, sometimes empty or the whole loaded prefix.
    function automatic logic [17:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 18'd0;
            1: return 18'(FILL_WORDS);
            default: return 18'($urandom_range(1, FILL_WORDS));
        endcase
    endfunction

    // One random item: mostly ticks, with loads and spare commands mixed in.
    task automatic send_random();
        int pick;
        logic [15:0] dens;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_item(CMD_TICK, 13'($urandom), 16'($urandom));
            else if (pick < 77)
            begin
                dens = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 12))
                                                   : 16'($urandom);
                send_item(CMD_DENS,
                          ($urandom_range(0, 3) == 0) ? 13'($urandom)
                                                      : 13'($urandom_range(0, 9)),
                          dens);
            end
            else if (pick < 95)
                send_item(3'($urandom_range(1, 3)), 13'($urandom), 16'($urandom));
            else
                send_item(3'($urandom_range(5, 7)), 13'($urandom), 16'($urandom));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [17:0] rate;
        in_valid = 1'b0;
        command = CMD_TICK;
        address = '0;
        value = '0;
        cfg_we = 1'b0;
        cfg_index = REG_KICK_LEN;
        cfg_data = '0;
        burst_left = 0;
        hold_req = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Beats on every tick until the countdown becomes meaningful.
        write_reg(REG_RATE, 18'd0);

        // Fill the sample prefix that any voice length below can reach.
        for (int a = 0; a < FILL_WORDS; a++)
        begin
            send_item(CMD_KICK, 13'(a), 16'($urandom));
            send_item(CMD_SNARE, 13'(a), 16'($urandom));
            send_item(CMD_HIHAT, 13'(a), 16'($urandom));
        end
        wait_drained();

        // With a beat on every tick no voice gets past word 2 here, so lengths
        // above the depth are safe in this section.
        write_reg(REG_KICK_LEN, 18'd16383);
        write_reg(REG_SNARE_LEN, 18'(SAMPLE_DEPTH));
        write_reg(REG_HIHAT_LEN, 18'd3);
        write_reg(REG_SEQ_LEN, 18'd6);
        write_reg(REG_SPARE, 18'h3FFFF);

        // Directed: loudest mix, density saturation, ignored slots and commands.
        send_item(CMD_KICK, 13'd0, 16'h8000);
        send_item(CMD_SNARE, 13'd0, 16'h8000);
        send_item(CMD_HIHAT, 13'd0, 16'h8000);
        send_item(CMD_KICK, 13'd1, 16'h7FFF);
        send_item(CMD_SNARE, 13'd1, 16'h7FFF);
        send_item(CMD_HIHAT, 13'd1, 16'h7FFF);
        send_item(CMD_DENS, 13'd0, 16'd10);
        send_item(CMD_DENS, 13'd1, 16'h7FFF);
        send_item(CMD_DENS, 13'd2, 16'h8000);
        send_item(CMD_DENS, 13'd3, 16'd3);
        send_item(CMD_DENS, 13'd4, 16'd7);
        send_item(CMD_DENS, 13'd5, 16'd4);
        send_item(CMD_DENS, 13'd8191, 16'd2);
        send_item(CMD_SPARE_A, 13'd0, 16'd0);
        send_item(CMD_SPARE_B, 13'h1FFF, 16'hFFFF);
        send_item(CMD_SPARE_C, 13'h0AAA, 16'h5555);
        repeat (8) send_item(CMD_TICK, 13'd0, 16'd0);
        wait_drained();

        // Random phases; the tempo extremes come last since a long countdown sticks.
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 8)
                rate = 18'd8000;
            else if (phase == 9)
                rate = 18'd192000;
            else if (phase % 3 == 0)
                rate = 18'd0;
            else
                rate = 18'($urandom_range(1, 400));
            write_reg(REG_KICK_LEN, pick_length());
            write_reg(REG_SNARE_LEN, pick_length());
            write_reg(REG_HIHAT_LEN, pick_length());
            write_reg(REG_RATE, rate);
            case (phase)
                0: write_reg(REG_SEQ_LEN, 18'd0);
                1: write_reg(REG_SEQ_LEN, 18'd1);
                2: write_reg(REG_SEQ_LEN, 18'd15);
                3: write_reg(REG_SEQ_LEN, 18'd8);
                default: write_reg(REG_SEQ_LEN, 18'($urandom_range(0, 15)));
            endcase
            for (int n = 0; n < 55; n++)
            begin
                // One long receiver hold-off while the sender keeps offering.
                if (phase == 3 && n == 10) hold_req = 1;
                send_random();
            end
            wait_drained();
        end

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
sv/ddss_pkg.sv
sv/ddss_divider.sv
sv/ddss_datapath.sv
sv/ddss_ctrl.sv
sv/density_drum_sample_sequencer.sv
test/density_drum_sample_sequencer_checker.sv
test/density_drum_sample_sequencer_test.sv
